[sv/tad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tad_pkg;

  // Sample and derived widths
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned T_W = SAMPLE_BITS + 4;   // sample * 11
  localparam int unsigned N_W = T_W + 8;           // offset term in Q20

  // Series operand widths
  localparam int unsigned A_W    = 23;  // clamped a, up to 4.0 in Q20
  localparam int unsigned A2_W   = 25;  // a^2, up to 16.0
  localparam int unsigned P_W    = 31;  // a^3 or a^5; a^7 is also stored here, truncated
  localparam int unsigned X_W    = 26;  // dividend for the small divides
  localparam int unsigned MB_W   = 25;  // second multiplier operand
  localparam int unsigned PROD_W = P_W + MB_W;
  localparam int unsigned PW_W   = PROD_W - 20;
  localparam int unsigned Q_W    = 25;  // quotient of a small divide
  localparam int unsigned S_W    = 27;  // series sum in Q20

  localparam logic [N_W-1:0] HALF_SPAN_Q20 = N_W'(5767168);
  localparam logic [N_W-1:0] CLAMP_Q20     = N_W'(4194304);
  localparam logic [X_W-1:0] X_MAX         = {X_W{1'b1}};

  // Reciprocals floor(2^26/d) for the divide-by-constant steps
  localparam int unsigned RCP_SHIFT = 26;
  localparam logic [MB_W-1:0] RCP_3 = MB_W'(22369621);
  localparam logic [MB_W-1:0] RCP_5 = MB_W'(13421772);
  localparam logic [MB_W-1:0] RCP_7 = MB_W'(9586980);

  localparam logic [7:0] MODE_BAR      = 8'hC7;
  localparam logic [7:0] MODE_DIGITS   = 8'hC3;
  localparam logic [7:0] BAR_FULL_HALF = 8'h4F;
  localparam logic [6:0] ANGLE_MAX     = 7'd99;

  typedef logic [3:0] pc_t;
  localparam pc_t STEP_FIN = 4'd15;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_MUL,
    OP_POW,
    OP_FIX,
    OP_FIN
  } op_e;

  typedef enum logic [1:0] {
    MA_A,
    MA_A2,
    MA_P,
    MA_X
  } mula_e;

  typedef enum logic [1:0] {
    MB_A,
    MB_A2,
    MB_RCP
  } mulb_e;

  typedef enum logic [1:0] {
    DV_3,
    DV_5,
    DV_7
  } div_e;

  typedef struct packed {
    op_e   op;
    mula_e ma;
    mulb_e mb;
    div_e  dv;
    logic  to_a2;   // power step writes a^2 instead of the odd power
    logic  jz;      // jump to target when the tilt is not positive
    pc_t   target;
  } ucode_t;

  function automatic ucode_t uc(op_e op, mula_e ma, mulb_e mb, div_e dv, logic to_a2,
                                logic jz, pc_t target);
    ucode_t w;
    w.op     = op;
    w.ma     = ma;
    w.mb     = mb;
    w.dv     = dv;
    w.to_a2  = to_a2;
    w.jz     = jz;
    w.target = target;
    return w;
  endfunction

  // Microprogram: powers of a, each odd term through a reciprocal divide
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    case (pc)
      4'd0:    w = uc(OP_LOAD, MA_A,  MB_A,   DV_3, 1'b0, 1'b1, STEP_FIN);
      4'd1:    w = uc(OP_MUL,  MA_A,  MB_A,   DV_3, 1'b0, 1'b0, 4'd0);
      4'd2:    w = uc(OP_POW,  MA_A,  MB_A,   DV_3, 1'b1, 1'b0, 4'd0);
      4'd3:    w = uc(OP_MUL,  MA_A2, MB_A,   DV_3, 1'b0, 1'b0, 4'd0);
      4'd4:    w = uc(OP_POW,  MA_A,  MB_A,   DV_3, 1'b0, 1'b0, 4'd0);
      4'd5:    w = uc(OP_MUL,  MA_X,  MB_RCP, DV_3, 1'b0, 1'b0, 4'd0);
      4'd6:    w = uc(OP_FIX,  MA_A,  MB_A,   DV_3, 1'b0, 1'b0, 4'd0);
      4'd7:    w = uc(OP_MUL,  MA_P,  MB_A2,  DV_5, 1'b0, 1'b0, 4'd0);
      4'd8:    w = uc(OP_POW,  MA_A,  MB_A,   DV_5, 1'b0, 1'b0, 4'd0);
      4'd9:    w = uc(OP_MUL,  MA_X,  MB_RCP, DV_5, 1'b0, 1'b0, 4'd0);
      4'd10:   w = uc(OP_FIX,  MA_A,  MB_A,   DV_5, 1'b0, 1'b0, 4'd0);
      4'd11:   w = uc(OP_MUL,  MA_P,  MB_A2,  DV_7, 1'b0, 1'b0, 4'd0);
      4'd12:   w = uc(OP_POW,  MA_A,  MB_A,   DV_7, 1'b0, 1'b0, 4'd0);
      4'd13:   w = uc(OP_MUL,  MA_X,  MB_RCP, DV_7, 1'b0, 1'b0, 4'd0);
      4'd14:   w = uc(OP_FIX,  MA_A,  MB_A,   DV_7, 1'b0, 1'b0, 4'd0);
      4'd15:   w = uc(OP_FIN,  MA_A,  MB_A,   DV_3, 1'b0, 1'b0, 4'd0);
      default: w = uc(OP_FIN,  MA_A,  MB_A,   DV_3, 1'b0, 1'b0, 4'd0);
    endcase
    return w;
  endfunction

  // Tens digit of an angle 0..99
  function automatic logic [3:0] tens_of(logic [6:0] ang);
    logic [3:0] t;
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (ang >= 7'(10 * i)) t = 4'(i);
    end
    return t;
  endfunction

  // Lower half of the bar for angles 5..54, in steps of ten
  function automatic logic [7:0] bar_lo(logic [6:0] ang);
    logic [7:0] b;
    if (ang < 7'd15)      b = 8'h01;
    else if (ang < 7'd25) b = 8'h03;
    else if (ang < 7'd35) b = 8'h07;
    else if (ang < 7'd45) b = 8'h0F;
    else                  b = BAR_FULL_HALF;
    return b;
  endfunction

  // Upper half of the bar for angles 55..89
  function automatic logic [7:0] bar_hi(logic [6:0] ang);
    logic [7:0] b;
    if (ang < 7'd65)      b = 8'h01;
    else if (ang < 7'd75) b = 8'h03;
    else if (ang < 7'd85) b = 8'h07;
    else                  b = 8'h0F;
    return b;
  endfunction

endpackage
`default_nettype wire

[sv/tad_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface tad_in_if;
  import tad_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [7:0]             switch_code;

  modport source (output valid, output sample, output switch_code, input ready);
  modport sink   (input valid, input sample, input switch_code, output ready);
endinterface

interface tad_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] angle_deg;
  logic [7:0] port_high;
  logic [7:0] port_low;

  modport source (output valid, output angle_deg, output port_high, output port_low,
                  input ready);
  modport sink   (input valid, input angle_deg, input port_high, input port_low,
                  output ready);
endinterface
`default_nettype wire

[sv/tilt_angle_led_display.sv]
// A request runs the 16-step microprogram, which sends every product through one shared
//   31x25 multiplier; a non-positive tilt jumps from the load step to the finish step.
//   Requests are taken only while idle; the finish step waits while an unread result is held.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous) clears the sequencer, the output valid and both
//   held display ports to zero.
`timescale 1ns / 1ps
`default_nettype none
module tilt_angle_led_display
  import tad_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  tad_in_if.sink     in_i,
  tad_out_if.source  out_o
);

  // Control state
  logic busy_q, busy_d;
  pc_t  pc_q, pc_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] held_high_q, held_high_d;
  logic [7:0] held_low_q, held_low_d;

  // Datapath registers
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [7:0]             switch_q;
  logic [A_W-1:0]         a_q;
  logic [A2_W-1:0]        a2_q;
  logic [P_W-1:0]         p_q;
  logic [X_W-1:0]         x_q;
  logic [PROD_W-1:0]      prod_q;
  logic [S_W-1:0]         s_q;
  logic [6:0]             angle_q;

  ucode_t uw;
  logic   in_fire, fin_go, pos;

  logic [T_W-1:0]    t11;
  logic [11:0]       h12, l12;
  logic [12:0]       hl;
  logic [N_W-1:0]    n_val, a_raw;
  logic [A_W-1:0]    a_clamp;

  logic [P_W-1:0]    mul_a;
  logic [MB_W-1:0]   mul_b, rcp;
  logic [PROD_W-1:0] mul_p;

  logic [PW_W-1:0]   pw;
  logic [PW_W+2:0]   pw_scaled;
  logic [X_W-1:0]    x_new;

  logic [Q_W-1:0]    q_est;
  logic [Q_W+2:0]    q_mul;
  logic [Q_W+2:0]    rem;
  logic [Q_W+2:0]    dval;
  logic              q_corr;

  logic [S_W+5:0]    s60;
  logic [12:0]       deg_w;
  logic [6:0]        ang;

  assign uw      = ucode_rom(pc_q);
  assign in_fire = in_i.valid && in_i.ready;
  assign fin_go  = busy_q && (uw.op == OP_FIN) && (!out_valid_q || out_o.ready);

  // Offset term n = floor(sample*11*2^20/4095) by shifts and one correction
  always_comb begin
    t11     = (T_W'(sample_q) << 3) + (T_W'(sample_q) << 1) + T_W'(sample_q);
    h12     = t11[T_W-1:4];
    l12     = {t11[3:0], 8'h00};
    hl      = {1'b0, h12} + {1'b0, l12};
    n_val   = {t11, 8'h00} + N_W'(h12) + N_W'(hl >= 13'd4095);
    pos     = n_val > HALF_SPAN_Q20;
    a_raw   = n_val - HALF_SPAN_Q20;
    a_clamp = (a_raw > CLAMP_Q20) ? CLAMP_Q20[A_W-1:0] : a_raw[A_W-1:0];
  end

  // Select multiplier operands and the divide constant
  always_comb begin
    case (uw.dv)
      DV_3:    begin rcp = RCP_3; dval = (Q_W+3)'(3); end
      DV_5:    begin rcp = RCP_5; dval = (Q_W+3)'(5); end
      DV_7:    begin rcp = RCP_7; dval = (Q_W+3)'(7); end
      default: begin rcp = RCP_3; dval = (Q_W+3)'(3); end
    endcase
    case (uw.ma)
      MA_A:    mul_a = P_W'(a_q);
      MA_A2:   mul_a = P_W'(a2_q);
      MA_P:    mul_a = p_q;
      MA_X:    mul_a = P_W'(x_q);
      default: mul_a = P_W'(a_q);
    endcase
    case (uw.mb)
      MB_A:    mul_b = MB_W'(a_q);
      MB_A2:   mul_b = a2_q;
      MB_RCP:  mul_b = rcp;
      default: mul_b = MB_W'(a_q);
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Rescale a fresh power into the dividend of its series term, capped
  always_comb begin
    pw = prod_q[PROD_W-1:20];
    case (uw.dv)
      DV_3:    pw_scaled = (PW_W+3)'(pw) >> 1;
      DV_5:    pw_scaled = ((PW_W+3)'(pw) + ((PW_W+3)'(pw) << 1)) >> 3;
      DV_7:    pw_scaled = ((PW_W+3)'(pw) + ((PW_W+3)'(pw) << 2)) >> 4;
      default: pw_scaled = (PW_W+3)'(pw) >> 1;
    endcase
    x_new = (pw_scaled > (PW_W+3)'(X_MAX)) ? X_MAX : pw_scaled[X_W-1:0];
  end

  // Correct the reciprocal quotient by one compare and subtract
  always_comb begin
    q_est = prod_q[RCP_SHIFT+Q_W-1:RCP_SHIFT];
    case (uw.dv)
      DV_3:    q_mul = ((Q_W+3)'(q_est) << 1) + (Q_W+3)'(q_est);
      DV_5:    q_mul = ((Q_W+3)'(q_est) << 2) + (Q_W+3)'(q_est);
      DV_7:    q_mul = ((Q_W+3)'(q_est) << 3) - (Q_W+3)'(q_est);
      default: q_mul = ((Q_W+3)'(q_est) << 1) + (Q_W+3)'(q_est);
    endcase
    rem    = (Q_W+3)'(x_q) - q_mul;
    q_corr = rem >= dval;
  end

  // Scale the sum by 60, drop the fraction, saturate
  always_comb begin
    s60   = ((S_W+6)'(s_q) << 6) - ((S_W+6)'(s_q) << 2);
    deg_w = s60[S_W+5:20];
    ang   = (deg_w > 13'(ANGLE_MAX)) ? ANGLE_MAX : deg_w[6:0];
  end

  // Next state of the sequencer
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (in_fire) begin
        busy_d = 1'b1;
        pc_d   = '0;
      end
    end else if (uw.op == OP_FIN) begin
      if (fin_go) begin
        busy_d = 1'b0;
        pc_d   = '0;
      end
    end else if (uw.jz && !pos) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  // Display ports and result valid
  always_comb begin
    held_high_d = held_high_q;
    held_low_d  = held_low_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (fin_go) begin
      out_valid_d = 1'b1;
      if (switch_q == MODE_BAR) begin
        if (ang < 7'd5) begin
          held_high_d = 8'h00;
          held_low_d  = 8'h00;
        end else if (ang < 7'd55) begin
          held_high_d = bar_lo(ang);
          held_low_d  = 8'h00;
        end else if (ang < 7'd90) begin
          held_high_d = BAR_FULL_HALF;
          held_low_d  = bar_hi(ang);
        end
      end else if (switch_q == MODE_DIGITS) begin
        held_low_d  = 8'(tens_of(ang));
        held_high_d = 8'(ang - 7'(tens_of(ang)) * 7'd10);
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      held_high_q <= 8'h00;
      held_low_q  <= 8'h00;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      held_high_q <= held_high_d;
      held_low_q  <= held_low_d;
    end
  end

  // Execute one control word on the datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_i.sample;
      switch_q <= in_i.switch_code;
    end
    if (busy_q) begin
      case (uw.op)
        OP_LOAD: begin
          a_q <= a_clamp;
          s_q <= pos ? S_W'(a_clamp) : '0;
        end
        OP_MUL: prod_q <= mul_p;
        OP_POW: begin
          if (uw.to_a2) begin
            a2_q <= pw[A2_W-1:0];
          end else begin
            p_q <= pw[P_W-1:0];
            x_q <= x_new;
          end
        end
        OP_FIX: s_q <= s_q + S_W'(q_est) + S_W'(q_corr);
        OP_FIN: begin
          if (fin_go) angle_q <= ang;
        end
        default: ;
      endcase
    end
  end

  assign in_i.ready      = !busy_q;
  assign out_o.valid     = out_valid_q;
  assign out_o.angle_deg = angle_q;
  assign out_o.port_high = held_high_q;
  assign out_o.port_low  = held_low_q;

  // Idle sequencer rests at the first step
  a_idle_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pc_q == '0)
    else $error("sequencer left its first step while idle");

  // A taken request starts the microprogram
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q && pc_q == '0)
    else $error("request did not start the sequencer");

  // Finishing step raises the result valid and frees the input
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_q && !busy_q)
    else $error("finish did not deliver a result");

  // Delivered angle stays within the display range
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> angle_q <= ANGLE_MAX)
    else $error("angle beyond saturation limit");

endmodule
`default_nettype wire
